// ===== rtl/core/nsr_pkg.sv =====
// Shared constants, types and reply byte lookup for the NTP server responder.
`default_nettype none

package nsr_pkg;

  localparam int unsigned PacketLen = 48;
  localparam int unsigned CountW = 6;

  localparam logic [31:0] UNIX_TO_NTP = 32'd2208988800;
  localparam logic [7:0]  HEADER_BYTE = 8'h24;
  localparam logic [2:0]  MODE_CLIENT = 3'd3;
  localparam logic [7:0]  PRECISION_BYTE = 8'hEC;

  localparam logic [CountW-1:0] LAST_POS = CountW'(PacketLen - 1);
  localparam logic [CountW-1:0] FULL_COUNT = CountW'(PacketLen);
  localparam logic [CountW-1:0] POLL_POS = 6'd2;
  localparam logic [CountW-1:0] XMIT_POS = 6'd40;

  localparam logic CFG_STRATUM = 1'b0;
  localparam logic CFG_REF_ID = 1'b1;

  typedef struct packed {
    logic [7:0]  poll;
    logic [63:0] client_xmit;
    logic [31:0] ntp_sec;
  } capture_t;

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0: b = v[31:24];
      2'd1: b = v[23:16];
      2'd2: b = v[15:8];
      2'd3: b = v[7:0];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] reply_byte(
    input logic [CountW-1:0] k,
    input logic [7:0]        stratum,
    input logic [31:0]       ref_id,
    input capture_t          cap
  );
    logic [7:0] b;
    b = 8'h00;
    if (k == 6'd0) b = HEADER_BYTE;
    else if (k == 6'd1) b = stratum;
    else if (k == 6'd2) b = cap.poll;
    else if (k == 6'd3) b = PRECISION_BYTE;
    else if (k >= 6'd12 && k <= 6'd15) b = be_byte(ref_id, k[1:0]);
    else if (k >= 6'd16 && k <= 6'd19) b = be_byte(cap.ntp_sec, k[1:0]);
    else if (k >= 6'd24 && k <= 6'd27) b = be_byte(cap.client_xmit[63:32], k[1:0]);
    else if (k >= 6'd28 && k <= 6'd31) b = be_byte(cap.client_xmit[31:0], k[1:0]);
    else if (k >= 6'd32 && k <= 6'd35) b = be_byte(cap.ntp_sec, k[1:0]);
    else if (k >= 6'd40 && k <= 6'd43) b = be_byte(cap.ntp_sec, k[1:0]);
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nsr_parser.sv =====
// Request parser: byte counter, field capture and request check.
`default_nettype none

module nsr_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire logic [7:0]       request_byte,
  input  wire logic             last_byte,
  input  wire logic [31:0]      unix_seconds,
  output nsr_pkg::capture_t     cap,
  output logic                  launch
);
  import nsr_pkg::*;

  logic [CountW-1:0] byte_count;
  logic [CountW-1:0] count_next;
  logic [2:0]        mode_bits;
  logic [2:0]        mode_next;
  logic [7:0]        poll_value;
  logic [63:0]       client_transmit;
  logic [31:0]       ntp_sec;
  logic              ok;

  always_comb begin
    count_next = (byte_count < FULL_COUNT) ? byte_count + 6'd1 : byte_count;
    mode_next = (byte_count == 6'd0) ? request_byte[2:0] : mode_bits;
    ok = (count_next >= FULL_COUNT) && (mode_next == MODE_CLIENT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      mode_bits <= '0;
      poll_value <= '0;
      client_transmit <= '0;
      ntp_sec <= '0;
      launch <= 1'b0;
    end else begin
      launch <= 1'b0;
      if (take) begin
        mode_bits <= mode_next;
        if (byte_count == POLL_POS) poll_value <= request_byte;
        if (byte_count >= XMIT_POS && byte_count < FULL_COUNT)
          client_transmit <= {client_transmit[55:0], request_byte};
        if (last_byte) begin
          byte_count <= '0;
          launch <= ok;
          ntp_sec <= unix_seconds + UNIX_TO_NTP;
        end else begin
          byte_count <= count_next;
        end
      end
    end
  end

  assign cap.poll = poll_value;
  assign cap.client_xmit = client_transmit;
  assign cap.ntp_sec = ntp_sec;

endmodule

`default_nettype wire

// ===== rtl/core/nsr_reply.sv =====
// Reply sequencer: steps through the 48 reply bytes into an output register.
`default_nettype none

module nsr_reply (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              launch,
  input  wire nsr_pkg::capture_t cap,
  input  wire logic [7:0]        stratum,
  input  wire logic [31:0]       ref_id,
  output logic                   busy,
  output logic                   response_valid,
  input  wire logic              response_stall,
  output logic [7:0]             response_byte,
  output logic                   response_last
);
  import nsr_pkg::*;

  logic [CountW-1:0] idx;
  logic              load;

  assign load = busy && (!response_valid || !response_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
      response_valid <= 1'b0;
    end else begin
      if (launch) begin
        busy <= 1'b1;
        idx <= '0;
      end else if (load) begin
        idx <= idx + 6'd1;
        if (idx == LAST_POS) busy <= 1'b0;
      end
      if (load) response_valid <= 1'b1;
      else if (!response_stall) response_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      response_byte <= reply_byte(idx, stratum, ref_id, cap);
      response_last <= (idx == LAST_POS);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ntp_server_responder.sv =====
// Top level of the NTP server responder: config registers, parser and reply sequencer.
//
// Request channel: one payload byte per beat (request_byte, last_byte, and
// unix_seconds, which is used with the last byte), request_valid/request_stall.
// Response channel: one reply byte per beat, response_last on byte 47,
// response_valid/response_stall.
// Config channel: cfg_valid/cfg_ready, always ready; index 0 is the stratum,
// index 1 the reference id.
// Request bytes are taken one per cycle while request_stall is low. When the
// last byte closes a valid client request (48 or more bytes, mode 3) a 48-byte
// reply follows: the parser's launch strobe sets the busy flag, which loads the
// first reply byte into the output register, then one byte per cycle while the
// receiver does not stall. Invalid requests are dropped. The request side stalls
// from the last byte of an accepted request until the reply sequencer has loaded
// byte 47 into its output register.
// A receiver stall holds the output register and pauses the sequencer.
// Reset clears the counters, captured fields and any reply in progress, sets
// the stratum to 1 and the reference id to 0.
`default_nettype none

module ntp_server_responder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        request_valid,
  output logic             request_stall,
  input  wire logic [7:0]  request_byte,
  input  wire logic        last_byte,
  input  wire logic [31:0] unix_seconds,
  output logic             response_valid,
  input  wire logic        response_stall,
  output logic [7:0]       response_byte,
  output logic             response_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import nsr_pkg::*;

  logic [7:0]  stratum_level;
  logic [31:0] reference_ident;
  capture_t    cap;
  logic        launch;
  logic        busy;
  logic        take;

  assign cfg_ready = 1'b1;
  assign request_stall = launch || busy;
  assign take = request_valid && !request_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stratum_level <= 8'd1;
      reference_ident <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STRATUM: stratum_level <= cfg_data[7:0];
        CFG_REF_ID: reference_ident <= cfg_data;
        default: ;
      endcase
    end
  end

  nsr_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .request_byte (request_byte),
    .last_byte    (last_byte),
    .unix_seconds (unix_seconds),
    .cap          (cap),
    .launch       (launch)
  );

  nsr_reply u_reply (
    .clk            (clk),
    .rst            (rst),
    .launch         (launch),
    .cap            (cap),
    .stratum        (stratum_level),
    .ref_id         (reference_ident),
    .busy           (busy),
    .response_valid (response_valid),
    .response_stall (response_stall),
    .response_byte  (response_byte),
    .response_last  (response_last)
  );

endmodule

`default_nettype wire
